>>> rtl/cfuv_pkg.sv
// Package for the cube face / coordinate pipeline.
// Widths, pipeline payload types and the restoring divider step.
// No dependencies.
package cfuv_pkg;

  localparam int CompBits  = 16;
  localparam int FracBits  = 16;
  localparam int MagBits   = CompBits + 1;      // |component|, exact for the most negative
  localparam int CoordBits = FracBits + 1;      // 0 .. 1.0 inclusive
  localparam int DivBits   = MagBits;           // divisor 2m fits: m <= 2^(CompBits-1)
  localparam int RemBits   = DivBits - 1;       // remainder < divisor
  localparam int StepsPerStage = 4;
  localparam int DivStages = CompBits / StepsPerStage;
  localparam int InBytes   = (3 * CompBits + 7) / 8;
  localparam int OutBytes  = (3 + 2 * CoordBits + 7) / 8;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  // one quotient lane: running remainder and quotient bits so far
  typedef struct packed {
    logic [RemBits-1:0]   rem;
    logic [CoordBits-1:0] quo;
  } lane_t;

  // payload between divider stages
  typedef struct packed {
    face_t                face;
    logic                 zero;
    logic [DivBits-1:0]   dvs;      // 2m
    logic [CompBits-1:0]  mlo;      // low numerator bits (m), msb next
    lane_t                lu;
    lane_t                lv;
  } div_word_t;

  // one restoring step: shift in a numerator bit, subtract when it fits
  function automatic lane_t div_step(lane_t l, logic nb, logic [DivBits-1:0] d);
    logic [RemBits:0] sh;
    lane_t            o;
    sh = {l.rem, nb};
    o.quo = {l.quo[CoordBits-2:0], 1'b0};
    if (sh >= d) begin
      o.rem = RemBits'(sh - d);
      o.quo[0] = 1'b1;
    end else begin
      o.rem = sh[RemBits-1:0];
    end
    return o;
  endfunction

endpackage

>>> rtl/cfuv_select.sv
// Front end: magnitudes, major axis, face, numerators, divider setup.
// Two register stages. Depends on cfuv_pkg.
module cfuv_select (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [cfuv_pkg::CompBits-1:0] dir_x,
  input  logic signed [cfuv_pkg::CompBits-1:0] dir_y,
  input  logic signed [cfuv_pkg::CompBits-1:0] dir_z,
  output logic                          out_valid,
  output cfuv_pkg::div_word_t           out_word
);
  import cfuv_pkg::*;

  typedef struct packed {
    face_t                     face;
    logic [MagBits-1:0]        mag;
    logic signed [MagBits-1:0] ns;
    logic signed [MagBits-1:0] nt;
  } sel_t;

  logic [MagBits-1:0] ax, ay, az;
  logic signed [MagBits-1:0] xe, ye, ze;
  sel_t sel_nxt, sel_r;
  logic v1_r, v2_r;
  div_word_t w_nxt, w_r;
  logic signed [MagBits:0] su, sv;
  logic [MagBits-1:0] au, av;

  assign xe = MagBits'(dir_x);
  assign ye = MagBits'(dir_y);
  assign ze = MagBits'(dir_z);
  assign ax = xe[MagBits-1] ? MagBits'(-xe) : xe;
  assign ay = ye[MagBits-1] ? MagBits'(-ye) : ye;
  assign az = ze[MagBits-1] ? MagBits'(-ze) : ze;

  // pick major axis, ties to X then Y
  always_comb begin
    if (ax >= ay && ax >= az) begin
      sel_nxt.mag = ax;
      sel_nxt.nt  = ze;
      if (!dir_x[CompBits-1]) begin
        sel_nxt.face = FACE_POS_X; sel_nxt.ns = ye;
      end else begin
        sel_nxt.face = FACE_NEG_X; sel_nxt.ns = -ye;
      end
    end else if (ay >= az) begin
      sel_nxt.mag = ay;
      sel_nxt.nt  = ze;
      if (!dir_y[CompBits-1]) begin
        sel_nxt.face = FACE_POS_Y; sel_nxt.ns = -xe;
      end else begin
        sel_nxt.face = FACE_NEG_Y; sel_nxt.ns = xe;
      end
    end else begin
      sel_nxt.mag = az;
      sel_nxt.ns  = ye;
      if (!dir_z[CompBits-1]) begin
        sel_nxt.face = FACE_POS_Z; sel_nxt.nt = -xe;
      end else begin
        sel_nxt.face = FACE_NEG_Z; sel_nxt.nt = xe;
      end
    end
  end

  // offset numerators by m and take the leading quotient bit (a == 2m)
  assign su = (MagBits+1)'(sel_r.ns) + (MagBits+1)'(signed'({1'b0, sel_r.mag}));
  assign sv = (MagBits+1)'(sel_r.nt) + (MagBits+1)'(signed'({1'b0, sel_r.mag}));
  assign au = su[MagBits-1:0];
  assign av = sv[MagBits-1:0];

  always_comb begin
    w_nxt.face = sel_r.face;
    w_nxt.zero = (sel_r.mag == '0);
    w_nxt.dvs  = DivBits'({sel_r.mag, 1'b0});
    w_nxt.mlo  = sel_r.mag[CompBits-1:0];
    w_nxt.lu.quo = '0;
    w_nxt.lv.quo = '0;
    if (au == w_nxt.dvs) begin
      w_nxt.lu.quo[0] = 1'b1; w_nxt.lu.rem = '0;
    end else begin
      w_nxt.lu.rem = au[RemBits-1:0];
    end
    if (av == w_nxt.dvs) begin
      w_nxt.lv.quo[0] = 1'b1; w_nxt.lv.rem = '0;
    end else begin
      w_nxt.lv.rem = av[RemBits-1:0];
    end
  end

  // hold control under stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      sel_r <= sel_nxt;
      w_r   <= w_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_word  = w_r;
endmodule

>>> rtl/cfuv_div_stage.sv
// One divider stage: several restoring steps on both coordinate lanes.
// Depends on cfuv_pkg.
module cfuv_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  cfuv_pkg::div_word_t in_word,
  output logic                out_valid,
  output cfuv_pkg::div_word_t out_word
);
  import cfuv_pkg::*;

  div_word_t w_nxt, w_r;
  logic      v_r;

  // walk the numerator bits, msb first
  always_comb begin
    w_nxt = in_word;
    for (int i = 0; i < StepsPerStage; i++) begin
      w_nxt.lu  = div_step(w_nxt.lu, w_nxt.mlo[CompBits-1], w_nxt.dvs);
      w_nxt.lv  = div_step(w_nxt.lv, w_nxt.mlo[CompBits-1], w_nxt.dvs);
      w_nxt.mlo = {w_nxt.mlo[CompBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_word  = w_r;
endmodule

>>> rtl/cube_face_uv_from_direction.sv
// Top level of the cube face / coordinate pipeline.
// Depends on cfuv_pkg, cfuv_select and cfuv_div_stage.
//
// Usage:
//   Input stream in_*: one direction word per handshake, tdata holds
//   dir_x, dir_y, dir_z (16-bit two's complement each, x lowest).
//   Output stream out_*: one word per input word, in order; tdata holds
//   face, coord_u, coord_v, tuser holds zero_vector.
//   Between input handshake and out_tvalid lie two front-end
//   stages (axis select, divider setup) and four divider stages of four
//   restoring steps each, per coordinate lane.
//   Throughput is one word per cycle between stalls; the six stages move as one.
//   When the receiver stalls with a word waiting at the output, every stage
//   holds and in_tready drops, so nothing is lost or repeated; an output
//   register that is empty never blocks the input.
//   Reset (rst_n low, synchronous) clears all valid bits; payload is not
//   cleared. A zero direction returns face 0, u = v = one half, flag set.
module cube_face_uv_from_direction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] face, [19:3] coord_u, [36:20] coord_v, zero pad
  output logic        out_tuser   // [0] zero_vector
);
  import cfuv_pkg::*;

  logic                en;
  logic                v [DivStages+1];
  div_word_t           w [DivStages+1];
  div_word_t           fin;
  logic [CoordBits-1:0] cu, cv;

  // advance whenever the output slot is free or being taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  cfuv_select u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .dir_x    (in_tdata[CompBits-1:0]),
    .dir_y    (in_tdata[2*CompBits-1:CompBits]),
    .dir_z    (in_tdata[3*CompBits-1:2*CompBits]),
    .out_valid(v[0]),
    .out_word (w[0])
  );

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    cfuv_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v[g]),
      .in_word  (w[g]),
      .out_valid(v[g+1]),
      .out_word (w[g+1])
    );
  end

  // substitute one half for a zero direction
  assign fin = w[DivStages];
  assign cu  = fin.zero ? CoordBits'(1 << (FracBits-1)) : fin.lu.quo;
  assign cv  = fin.zero ? CoordBits'(1 << (FracBits-1)) : fin.lv.quo;

  assign out_tvalid = v[DivStages];
  assign out_tdata  = {(8*OutBytes - 3 - 2*CoordBits)'(0), cv, cu,
                       fin.zero ? FACE_POS_X : fin.face};
  assign out_tuser  = fin.zero;
endmodule

>>> rtl/cfuv_checker.sv
// Port-level checker for cube_face_uv_from_direction, with its bind.
// Depends on nothing beyond the top level's ports.
module cfuv_port_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser
);
  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed under stall");

  // zero direction reports face 0 and the center of the face
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2:0] == 3'd0 &&
      out_tdata[19:3] == 17'd32768 && out_tdata[36:20] == 17'd32768)
    else $error("zero vector result wrong");

  // coordinates stay in [0, 1.0] and face in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[19:3] <= 17'd65536 && out_tdata[36:20] <= 17'd65536 &&
      out_tdata[2:0] <= 3'd5 && out_tdata[39:37] == 3'd0)
    else $error("output out of range");

  // input is taken whenever the output is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");
endmodule

bind cube_face_uv_from_direction cfuv_port_checker u_cfuv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

>>> dv/cfuv_checker.sv
// Checker for the cube face / coordinate pipeline: predicts each result from
// the accepted direction words and compares the output stream. Uses cfuv_pkg.
`timescale 1ns / 1ps

module cfuv_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser,
  output int          errors,
  output int          pending
);
  import cfuv_pkg::*;

  typedef struct packed {
    face_t                face;
    logic [CoordBits-1:0] u;
    logic [CoordBits-1:0] v;
    logic                 zero;
  } face_uv_t;

  face_uv_t expected_uv[$];

  // round((n + m) * 2^F / 2m), exact half rounds up
  function automatic logic [CoordBits-1:0] proj_coord(longint n, longint m);
    longint a;
    a = ((n + m) << FracBits) + m;
    return CoordBits'(a / (2 * m));
  endfunction

  function automatic face_uv_t project_dir(logic [47:0] d);
    longint x, y, z, ax, ay, az, m, ns, nt;
    face_uv_t r;
    x = longint'($signed(d[15:0]));
    y = longint'($signed(d[31:16]));
    z = longint'($signed(d[47:32]));
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    if (ax >= ay && ax >= az) begin
      m = ax;
      if (x >= 0) begin r.face = FACE_POS_X; ns = y; nt = z; end
      else begin r.face = FACE_NEG_X; ns = -y; nt = z; end
    end else if (ay >= az) begin
      m = ay;
      if (y >= 0) begin r.face = FACE_POS_Y; ns = -x; nt = z; end
      else begin r.face = FACE_NEG_Y; ns = x; nt = z; end
    end else begin
      m = az;
      if (z >= 0) begin r.face = FACE_POS_Z; ns = y; nt = -x; end
      else begin r.face = FACE_NEG_Z; ns = y; nt = x; end
    end
    if (m == 0) begin
      r.face = FACE_POS_X;
      r.u = CoordBits'(1) << (FracBits - 1);
      r.v = CoordBits'(1) << (FracBits - 1);
      r.zero = 1'b1;
    end else begin
      r.u = proj_coord(ns, m);
      r.v = proj_coord(nt, m);
      r.zero = 1'b0;
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("checker: %s mismatch got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  initial errors = 0;
  assign pending = expected_uv.size();

  // push predictions on input words, compare on output words
  always @(posedge clk) begin
    face_uv_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_uv.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        w = expected_uv.pop_front();
        if (out_tdata[2:0] !== w.face) report("face", out_tdata[2:0], w.face);
        if (out_tdata[19:3] !== w.u) report("coord_u", out_tdata[19:3], w.u);
        if (out_tdata[36:20] !== w.v) report("coord_v", out_tdata[36:20], w.v);
        if (out_tuser !== w.zero) report("zero_vector", out_tuser, w.zero);
      end
    end
    if (rst_n && in_tvalid && in_tready) expected_uv.push_back(project_dir(in_tdata));
  end

endmodule

>>> dv/tb.sv
// Testbench top for cube_face_uv_from_direction: drives direction words with
// random gaps and receiver stalls; cfuv_checker does the comparing.
`timescale 1ns / 1ps

module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  int          errors;
  int          pending;
  logic        calm = 1'b0;
  logic        long_hold = 1'b0;
  int          sent = 0;

  always #10 clk = ~clk;

  cube_face_uv_from_direction dut (.*);

  cfuv_checker chk (.*);

  // send one word, hold until accepted
  task automatic send_dir(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stall bursts, a long hold on request, none when calm
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        n = 0;
        while (n < 60) begin @(negedge clk); n++; end
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    logic [15:0] v;
    int i;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: zero, each face, ties, extremes, rounding
    send_dir(16'd0, 16'd0, 16'd0);
    send_dir(16'd100, 16'd3, -16'sd7);
    send_dir(-16'sd100, 16'd3, -16'sd7);
    send_dir(16'd3, 16'd100, -16'sd7);
    send_dir(16'd3, -16'sd100, -16'sd7);
    send_dir(16'd3, -16'sd7, 16'd100);
    send_dir(16'd3, -16'sd7, -16'sd100);
    send_dir(16'd5, 16'd5, 16'd5);
    send_dir(-16'sd5, 16'd5, -16'sd5);
    send_dir(16'd2, -16'sd9, 16'd9);
    send_dir(16'h8000, 16'h8000, 16'h8000);
    send_dir(16'h8000, 16'h7fff, 16'h0001);
    send_dir(16'h7fff, 16'h8001, 16'h7fff);
    send_dir(16'h7fff, 16'hffff, 16'd0);
    send_dir(16'd0, 16'd0, 16'h8000);
    send_dir(16'd1, 16'd0, 16'd0);
    send_dir(16'd0, 16'hffff, 16'd0);
    send_dir(16'd3, 16'd1, 16'd2);
    send_dir(16'hffff, 16'hffff, 16'hffff);
    send_dir(16'haaaa, 16'h5555, 16'h1234);
    // sender pause until drained
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // fill the pipeline against a long receiver hold
    long_hold = 1'b1;
    for (i = 0; i < 20; i++) send_dir(rand_comp(), rand_comp(), 16'($urandom));
    for (i = 0; i < 400; i++) begin
      if (i == 340) calm = 1'b1;
      v = rand_comp();
      case ($urandom_range(0, 3))
        0: send_dir(v, rand_comp(), rand_comp());
        1: send_dir(rand_comp(), v, v ^ 16'($urandom_range(0, 1)));
        default: send_dir(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("tb: %0d directions sent: all faces, ties, zero vector, extremes,", sent);
    $display("tb: random gaps and stalls with a full-pipeline backpressure hold");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

>>> cube_face_uv_from_direction.f
rtl/cfuv_pkg.sv
rtl/cfuv_select.sv
rtl/cfuv_div_stage.sv
rtl/cube_face_uv_from_direction.sv
rtl/cfuv_checker.sv
dv/cfuv_checker.sv
dv/tb.sv
